// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the CSR builder blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define ELCSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ELCSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ELCSR_ASSERT(label, clk, rst, prop, msg)
`define ELCSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/elcsr_pkg.sv =====
// ---------------------------------------------------------------------------
// elcsr_pkg
// Sizes, codes and controller/datapath interface types of the CSR builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package elcsr_pkg;

   localparam int MAX_NODES      = 1024;
   localparam int MAX_EDGES      = 4096;
   localparam int KIND_BITS      = 8;

   localparam int NODE_BITS      = $clog2(MAX_NODES);
   localparam int NCOUNT_BITS    = NODE_BITS + 1;
   localparam int EDGE_ADDR_BITS = $clog2(MAX_EDGES);
   localparam int COUNT_BITS     = EDGE_ADDR_BITS + 1;
   localparam int INDEX_BITS     = 12;
   localparam int VALUE_BITS     = 13;
   localparam int STATUS_BITS    = 3;
   localparam int OP_BITS        = 2;
   localparam int RAW_BITS       = 2 * NODE_BITS + KIND_BITS;
   localparam int CSR_BITS       = NODE_BITS + KIND_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD        = 2'd0,
      OP_BUILD       = 2'd1,
      OP_READ_OFFSET = 2'd2,
      OP_READ_EDGE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      RSP_OK        = 3'd0,
      RSP_FROZEN    = 3'd1,
      RSP_FULL      = 3'd2,
      RSP_RANGE     = 3'd3,
      RSP_NOT_BUILT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      STEP_IDLE    = 4'd0,
      STEP_CAPTURE = 4'd1,
      STEP_INIT    = 4'd2,
      STEP_CLEAR   = 4'd3,
      STEP_CNT_RAW = 4'd4,
      STEP_CNT_OFF = 4'd5,
      STEP_CNT_WR  = 4'd6,
      STEP_PFX_RD  = 4'd7,
      STEP_PFX_WR  = 4'd8,
      STEP_SCT_RAW = 4'd9,
      STEP_SCT_CUR = 4'd10,
      STEP_SCT_WR  = 4'd11,
      STEP_READ    = 4'd12,
      STEP_FINISH  = 4'd13
   } step_type;

   typedef struct packed {
      step_type step;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic frozen;
      logic clear_last;
      logic edges_done;
      logic src_ok;
      logic pfx_done;
      logic out_blocked;
   } dp_status_type;

endpackage

// ===== design/elcsr_dp.sv =====
// ---------------------------------------------------------------------------
// elcsr_dp
// Datapath: raw edge, row offset, cursor and CSR stores, loop counters and
// the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module elcsr_dp
   import elcsr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [OP_BITS-1:0]        req_op,
   input  logic [NODE_BITS-1:0]      req_source_node,
   input  logic [NODE_BITS-1:0]      req_target_node,
   input  logic [KIND_BITS-1:0]      req_edge_kind,
   input  logic [INDEX_BITS-1:0]     req_read_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [VALUE_BITS-1:0]     rsp_read_value,
   output logic [KIND_BITS-1:0]      rsp_read_kind,
   output logic [VALUE_BITS-1:0]     rsp_edge_total,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [NCOUNT_BITS-1:0]    csr_write_data,
   input  cmd_type                   cmd,
   output dp_status_type             status
);

   // Control registers.
   logic [NCOUNT_BITS-1:0] node_count_ff, node_count_in;
   logic                   frozen_ff, frozen_in;
   logic [NCOUNT_BITS-1:0] built_ff, built_in;
   logic [COUNT_BITS-1:0]  raw_count_ff, raw_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Request and working registers.
   op_type                 op_ff, op_in;
   logic [NODE_BITS-1:0]   src_ff, src_in;
   logic [NODE_BITS-1:0]   tgt_ff, tgt_in;
   logic [KIND_BITS-1:0]   kind_ff, kind_in;
   logic [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [NCOUNT_BITS-1:0] lim_ff, lim_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]  acc_ff, acc_in;
   logic [COUNT_BITS-1:0]  total_ff, total_in;

   // Result register.
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0]  res_value_ff, res_value_in;
   logic [KIND_BITS-1:0]   res_kind_ff, res_kind_in;
   logic [VALUE_BITS-1:0]  res_total_ff, res_total_in;

   // Memories and their ports.
   logic [RAW_BITS-1:0]    raw_mem [0:MAX_EDGES-1];
   logic [COUNT_BITS-1:0]  off_mem [0:MAX_NODES];
   logic [COUNT_BITS-1:0]  cur_mem [0:MAX_NODES-1];
   logic [CSR_BITS-1:0]    csr_mem [0:MAX_EDGES-1];

   logic                      raw_we, raw_re;
   logic [EDGE_ADDR_BITS-1:0] raw_wa, raw_ra;
   logic [RAW_BITS-1:0]       raw_wd, raw_rd_ff;

   logic                      off_we, off_re;
   logic [NCOUNT_BITS-1:0]    off_wa, off_ra;
   logic [COUNT_BITS-1:0]     off_wd, off_rd_ff;

   logic                      cur_we, cur_re;
   logic [NODE_BITS-1:0]      cur_wa, cur_ra;
   logic [COUNT_BITS-1:0]     cur_wd, cur_rd_ff;

   logic                      csr_we, csr_re;
   logic [EDGE_ADDR_BITS-1:0] csr_wa, csr_ra;
   logic [CSR_BITS-1:0]       csr_wd, csr_rd_ff;

   // Derived values.
   logic [NCOUNT_BITS-1:0] lim_sat;
   logic [NODE_BITS-1:0]   raw_src, raw_tgt;
   logic [KIND_BITS-1:0]   raw_kind;
   logic [NCOUNT_BITS-1:0] src_next;
   logic [COUNT_BITS-1:0]  pfx_sum, pfx_prev;
   logic                   store_full, idx_over_nodes, idx_over_total, build_ok;
   status_type             res_code;

   assign lim_sat  = (node_count_ff > NCOUNT_BITS'(MAX_NODES)) ?
                     NCOUNT_BITS'(MAX_NODES) : node_count_ff;
   assign raw_src  = raw_rd_ff[RAW_BITS-1 -: NODE_BITS];
   assign raw_tgt  = raw_rd_ff[KIND_BITS +: NODE_BITS];
   assign raw_kind = raw_rd_ff[KIND_BITS-1:0];
   assign src_next = NCOUNT_BITS'(raw_src) + NCOUNT_BITS'(1);
   assign pfx_sum  = acc_ff + off_rd_ff;
   assign pfx_prev = cnt_ff - COUNT_BITS'(1);

   assign store_full     = (raw_count_ff >= COUNT_BITS'(MAX_EDGES));
   assign idx_over_nodes = (idx_ff > INDEX_BITS'(built_ff));
   assign idx_over_total = (COUNT_BITS'(idx_ff) >= total_ff);
   assign build_ok       = (op_ff == OP_BUILD) && !frozen_ff;

   assign status.frozen      = frozen_ff;
   assign status.clear_last  = (cnt_ff == COUNT_BITS'(lim_ff));
   assign status.edges_done  = (cnt_ff == raw_count_ff);
   assign status.src_ok      = (NCOUNT_BITS'(raw_src) < lim_ff);
   assign status.pfx_done    = (cnt_ff > COUNT_BITS'(lim_ff));
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = res_status_ff;
   assign rsp_read_value = res_value_ff;
   assign rsp_read_kind  = res_kind_ff;
   assign rsp_edge_total = res_total_ff;

   // Result of the request held in the working registers.
   always_comb begin
      res_code  = RSP_OK;
      res_value_in = '0;
      res_kind_in  = '0;
      unique case (op_ff)
         OP_LOAD: begin
            if (frozen_ff) begin
               res_code = RSP_FROZEN;
            end else if (store_full) begin
               res_code = RSP_FULL;
            end
         end
         OP_BUILD: begin
            if (frozen_ff) begin
               res_code = RSP_FROZEN;
            end
         end
         OP_READ_OFFSET: begin
            if (!frozen_ff) begin
               res_code = RSP_NOT_BUILT;
            end else if (idx_over_nodes) begin
               res_code = RSP_RANGE;
            end else begin
               res_value_in = off_rd_ff;
            end
         end
         OP_READ_EDGE: begin
            if (!frozen_ff) begin
               res_code = RSP_NOT_BUILT;
            end else if (idx_over_total) begin
               res_code = RSP_RANGE;
            end else begin
               res_value_in = VALUE_BITS'(csr_rd_ff[CSR_BITS-1 -: NODE_BITS]);
               res_kind_in  = csr_rd_ff[KIND_BITS-1:0];
            end
         end
         default: begin
            res_code = RSP_OK;
         end
      endcase
      res_status_in = res_code;
      res_total_in  = (frozen_ff || build_ok) ? total_ff : '0;
   end

   // Next state of the registers and memory port controls.
   always_comb begin
      node_count_in = node_count_ff;
      frozen_in     = frozen_ff;
      built_in      = built_ff;
      raw_count_in  = raw_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      lim_in        = lim_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      total_in      = total_ff;

      raw_we = 1'b0;  raw_wa = raw_count_ff[EDGE_ADDR_BITS-1:0];
      raw_wd = {src_ff, tgt_ff, kind_ff};
      raw_re = 1'b0;  raw_ra = cnt_ff[EDGE_ADDR_BITS-1:0];
      off_we = 1'b0;  off_wa = cnt_ff[NCOUNT_BITS-1:0];  off_wd = '0;
      off_re = 1'b0;  off_ra = cnt_ff[NCOUNT_BITS-1:0];
      cur_we = 1'b0;  cur_wa = raw_src;  cur_wd = cur_rd_ff + COUNT_BITS'(1);
      cur_re = 1'b0;  cur_ra = raw_src;
      csr_we = 1'b0;  csr_wa = cur_rd_ff[EDGE_ADDR_BITS-1:0];
      csr_wd = {raw_tgt, raw_kind};
      csr_re = 1'b0;  csr_ra = idx_ff[EDGE_ADDR_BITS-1:0];

      if (csr_valid) begin
         node_count_in = csr_write_data;
      end

      unique case (cmd.step)
         STEP_IDLE: begin
         end
         STEP_CAPTURE: begin
            op_in   = op_type'(req_op);
            src_in  = req_source_node;
            tgt_in  = req_target_node;
            kind_in = req_edge_kind;
            idx_in  = req_read_index;
         end
         STEP_INIT: begin
            lim_in = lim_sat;
            cnt_in = '0;
            acc_in = '0;
         end
         STEP_CLEAR: begin
            off_we = 1'b1;
            cnt_in = status.clear_last ? '0 : cnt_ff + COUNT_BITS'(1);
         end
         STEP_CNT_RAW: begin
            if (status.edges_done) begin
               cnt_in = COUNT_BITS'(1);
            end else begin
               raw_re = 1'b1;
            end
         end
         STEP_CNT_OFF: begin
            if (status.src_ok) begin
               off_re = 1'b1;
               off_ra = src_next;
            end else begin
               cnt_in = cnt_ff + COUNT_BITS'(1);
            end
         end
         STEP_CNT_WR: begin
            off_we = 1'b1;
            off_wa = src_next;
            off_wd = off_rd_ff + COUNT_BITS'(1);
            cnt_in = cnt_ff + COUNT_BITS'(1);
         end
         STEP_PFX_RD: begin
            if (status.pfx_done) begin
               cnt_in   = '0;
               total_in = acc_ff;
            end else begin
               off_re = 1'b1;
            end
         end
         STEP_PFX_WR: begin
            off_we = 1'b1;
            off_wd = pfx_sum;
            cur_we = 1'b1;
            cur_wa = pfx_prev[NODE_BITS-1:0];
            cur_wd = acc_ff;
            acc_in = pfx_sum;
            cnt_in = cnt_ff + COUNT_BITS'(1);
         end
         STEP_SCT_RAW: begin
            if (!status.edges_done) begin
               raw_re = 1'b1;
            end
         end
         STEP_SCT_CUR: begin
            if (status.src_ok) begin
               cur_re = 1'b1;
            end else begin
               cnt_in = cnt_ff + COUNT_BITS'(1);
            end
         end
         STEP_SCT_WR: begin
            csr_we = (cur_rd_ff < COUNT_BITS'(MAX_EDGES));
            cur_we = 1'b1;
            cnt_in = cnt_ff + COUNT_BITS'(1);
         end
         STEP_READ: begin
            off_re = (op_ff == OP_READ_OFFSET) && frozen_ff && !idx_over_nodes;
            off_ra = idx_ff[NCOUNT_BITS-1:0];
            csr_re = (op_ff == OP_READ_EDGE) && frozen_ff && !idx_over_total;
         end
         STEP_FINISH: begin
         end
         default: begin
         end
      endcase

      // Handing the result over commits the side effects of the request.
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if ((op_ff == OP_LOAD) && !frozen_ff && !store_full) begin
            raw_we       = 1'b1;
            raw_count_in = raw_count_ff + COUNT_BITS'(1);
         end
         if (build_ok) begin
            frozen_in = 1'b1;
            built_in  = lim_ff;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         frozen_ff     <= 1'b0;
         built_ff      <= '0;
         raw_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         frozen_ff     <= frozen_in;
         built_ff      <= built_in;
         raw_count_ff  <= raw_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      src_ff   <= src_in;
      tgt_ff   <= tgt_in;
      kind_ff  <= kind_in;
      idx_ff   <= idx_in;
      lim_ff   <= lim_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      total_ff <= total_in;
      if (cmd.emit) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
         res_kind_ff   <= res_kind_in;
         res_total_ff  <= res_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (raw_we) begin
         raw_mem[raw_wa] <= raw_wd;
      end
      if (raw_re) begin
         raw_rd_ff <= raw_mem[raw_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem[off_wa] <= off_wd;
      end
      if (off_re) begin
         off_rd_ff <= off_mem[off_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_wa] <= cur_wd;
      end
      if (cur_re) begin
         cur_rd_ff <= cur_mem[cur_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (csr_we) begin
         csr_mem[csr_wa] <= csr_wd;
      end
      if (csr_re) begin
         csr_rd_ff <= csr_mem[csr_ra];
      end
   end

   // A result is only handed over when the output register can take it.
   `ELCSR_ASSERT(a_emit_free, clock, reset, cmd.emit |-> !(rsp_valid_ff && rsp_stall), "emit while output stalled")
   // Once built, the graph stays frozen until reset.
   `ELCSR_ASSERT_NEXT(a_frozen_holds, clock, reset, frozen_ff, frozen_ff, "frozen flag dropped")

endmodule

// ===== design/elcsr_ctrl.sv =====
// ---------------------------------------------------------------------------
// elcsr_ctrl
// Controller: sequences request handling and the phases of the build.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module elcsr_ctrl
   import elcsr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_BITS-1:0] req_op,
   input  dp_status_type      status,
   output cmd_type            cmd
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'h0001,
      S_INIT    = 13'h0002,
      S_CLEAR   = 13'h0004,
      S_CNT_RAW = 13'h0008,
      S_CNT_OFF = 13'h0010,
      S_CNT_WR  = 13'h0020,
      S_PFX_RD  = 13'h0040,
      S_PFX_WR  = 13'h0080,
      S_SCT_RAW = 13'h0100,
      S_SCT_CUR = 13'h0200,
      S_SCT_WR  = 13'h0400,
      S_READ    = 13'h0800,
      S_FINISH  = 13'h1000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.step = STEP_IDLE;
      cmd.emit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.step = STEP_CAPTURE;
               unique case (op_type'(req_op))
                  OP_LOAD:        state_in = S_FINISH;
                  OP_BUILD:       state_in = status.frozen ? S_FINISH : S_INIT;
                  OP_READ_OFFSET: state_in = S_READ;
                  OP_READ_EDGE:   state_in = S_READ;
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_INIT: begin
            cmd.step = STEP_INIT;
            state_in = S_CLEAR;
         end
         S_CLEAR: begin
            cmd.step = STEP_CLEAR;
            if (status.clear_last) begin
               state_in = S_CNT_RAW;
            end
         end
         S_CNT_RAW: begin
            cmd.step = STEP_CNT_RAW;
            state_in = status.edges_done ? S_PFX_RD : S_CNT_OFF;
         end
         S_CNT_OFF: begin
            cmd.step = STEP_CNT_OFF;
            state_in = status.src_ok ? S_CNT_WR : S_CNT_RAW;
         end
         S_CNT_WR: begin
            cmd.step = STEP_CNT_WR;
            state_in = S_CNT_RAW;
         end
         S_PFX_RD: begin
            cmd.step = STEP_PFX_RD;
            state_in = status.pfx_done ? S_SCT_RAW : S_PFX_WR;
         end
         S_PFX_WR: begin
            cmd.step = STEP_PFX_WR;
            state_in = S_PFX_RD;
         end
         S_SCT_RAW: begin
            cmd.step = STEP_SCT_RAW;
            state_in = status.edges_done ? S_FINISH : S_SCT_CUR;
         end
         S_SCT_CUR: begin
            cmd.step = STEP_SCT_CUR;
            state_in = status.src_ok ? S_SCT_WR : S_SCT_RAW;
         end
         S_SCT_WR: begin
            cmd.step = STEP_SCT_WR;
            state_in = S_SCT_RAW;
         end
         S_READ: begin
            cmd.step = STEP_READ;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.step = STEP_FINISH;
            if (!status.out_blocked) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted request always leaves the idle state.
   `ELCSR_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != S_IDLE, "request accepted but controller stayed idle")
   // The build phases are never entered on a frozen graph.
   `ELCSR_ASSERT(a_build_unfrozen, clock, reset, (state_ff == S_INIT) |-> !status.frozen, "build started on frozen graph")

endmodule

// ===== design/edge_list_to_csr_builder.sv =====
// ---------------------------------------------------------------------------
// edge_list_to_csr_builder
// Builds a compressed sparse row graph from a loaded edge list.
// ---------------------------------------------------------------------------
// Requests arrive on the req_ channel (valid/stall) and each one produces
// exactly one response on the rsp_ channel. The csr_ write channel sets
// the node count and is always ready; write it only while the block is idle.
// After acceptance a load passes through the finish state, and a read
// through the read state and then the finish state, since the stores have
// registered reads; requests are stalled until the controller is idle again.
// A build runs clearing, counting, prefix-sum and scatter passes over the
// offset and cursor memories, one read-modify-write at a time, before its
// response is emitted from the finish state.
// The next request is taken as soon as the response is in the output
// register, even while the receiver still stalls it; if a new response is
// ready while the old one is stalled, the controller holds until it drains.
// Reset clears the node count, the edge count, the frozen flag and the
// output valid; the memories keep no reset value (a build clears offsets).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_list_to_csr_builder
   import elcsr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_op,
   input  logic [NODE_BITS-1:0]   req_source_node,
   input  logic [NODE_BITS-1:0]   req_target_node,
   input  logic [KIND_BITS-1:0]   req_edge_kind,
   input  logic [INDEX_BITS-1:0]  req_read_index,
   // Response channel.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [VALUE_BITS-1:0]  rsp_read_value,
   output logic [KIND_BITS-1:0]   rsp_read_kind,
   output logic [VALUE_BITS-1:0]  rsp_edge_total,
   // Node count register write.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [NCOUNT_BITS-1:0] csr_write_data
);

   // The controller only sees status flags from the datapath and steers it
   // with a step code plus an emit strobe that commits the request.
   cmd_type       cmd;
   dp_status_type status;

   elcsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds all four stores, the loop counter and the running
   // prefix sum, and owns the response register.
   elcsr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_source_node (req_source_node),
      .req_target_node (req_target_node),
      .req_edge_kind   (req_edge_kind),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_read_kind   (rsp_read_kind),
      .rsp_edge_total  (rsp_edge_total),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
